/* sv/pee_pkg.sv */
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Item types, status codes and character constants of the evaluator; the
// checker shares the status codes and the result item type.
// ----------------------------------------------------------------------------
package pee_pkg;

  // Status reported with every result item
  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_RESULT     = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_TOO_FEW    = 3'd4,
    ST_INVALID    = 3'd5,
    ST_DISCARDED  = 3'd6
  } status_t;

  // ASCII codes the evaluator recognizes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  localparam int unsigned RES_WIDTH = 32;

  // One character of the expression
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } cmd_t;

  // One result item
  typedef struct packed {
    status_t                       status;
    logic signed [RES_WIDTH-1:0]   value;
    logic                          done_res;
  } rsp_t;

endpackage

/* sv/postfix_expression_evaluator_unit.sv */
// A result item is registered in the output register as its character is
// accepted, or in the skid entry while a stalled result still holds that register.
// Throughput: one character per cycle while cmd_stall is low; the stack top and
// the two entries below it are cached in registers over a one-write/one-read stack memory.
// cmd_stall rises only while the two-entry output buffer is full.
// Reset clears the stack count, the discard flag and the output buffer; the
// stack memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix expression one character per item on an operand stack
// and reports a status (and the final value) for every character.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit
  import pee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned VW = VALUE_WIDTH;

  // Stack state: tos = entry count-1, nos = count-2, third = count-3
  logic [CW-1:0] count;
  logic          discarding;
  logic [VW-1:0] tos;
  logic [VW-1:0] nos;
  logic [VW-1:0] third;
  logic [VW-1:0] stack_mem [STACK_DEPTH];

  logic [CW-1:0] count_next;
  logic          discarding_next;
  logic [VW-1:0] tos_next;
  logic [VW-1:0] nos_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic [CW-1:0] rd_index;

  logic          accept;
  logic          is_digit;
  logic          is_op;
  logic [7:0]    digit_code;
  logic [VW-1:0] digit_val;
  logic [VW-1:0] alu_res;
  logic [VW+RES_WIDTH-1:0] value_ext;
  rsp_t          new_rsp;

  // Output buffer: main register plus skid entry
  logic out_valid;
  rsp_t out_item;
  logic skid_valid;
  rsp_t skid_item;
  logic take;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = skid_valid;
  assign rsp_valid = out_valid;
  assign rsp       = out_item;
  assign take      = out_valid && !rsp_stall;

  // Character decode
  assign is_digit   = (cmd.char_code >= CH_ZERO) && (cmd.char_code <= CH_NINE);
  assign is_op      = (cmd.char_code == CH_PLUS) || (cmd.char_code == CH_MINUS) ||
                      (cmd.char_code == CH_STAR);
  assign digit_code = cmd.char_code - CH_ZERO;
  assign digit_val  = {{(VW-4){1'b0}}, digit_code[3:0]};

  // ALU: left operand is nos, right operand is tos
  always_comb begin
    alu_res = '0;
    unique case (cmd.char_code)
      CH_PLUS:  alu_res = nos + tos;
      CH_MINUS: alu_res = nos - tos;
      CH_STAR:  alu_res = VW'(nos * tos);
      default:  alu_res = '0;
    endcase
  end

  // Next stack state and result for the current character
  always_comb begin
    count_next      = count;
    discarding_next = discarding;
    tos_next        = tos;
    nos_next        = nos;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = digit_val;
    value_ext       = '0;
    new_rsp.status   = ST_ACCEPTED;
    new_rsp.value    = '0;
    new_rsp.done_res = 1'b0;

    if (discarding) begin
      new_rsp.status = ST_DISCARDED;
    end else if (is_digit) begin
      if (count == CW'(STACK_DEPTH)) begin
        new_rsp.status = ST_TOO_LONG;
      end else begin
        count_next = count + CW'(1);
        tos_next   = digit_val;
        nos_next   = tos;
        wr_en      = 1'b1;
        wr_addr    = count[AW-1:0];
        wr_data    = digit_val;
      end
    end else if (is_op) begin
      if (count < CW'(2)) begin
        new_rsp.status = ST_TOO_FEW;
      end else begin
        count_next = count - CW'(1);
        tos_next   = alu_res;
        nos_next   = third;
        wr_en      = 1'b1;
        wr_addr    = AW'(count - CW'(2));
        wr_data    = alu_res;
      end
    end else begin
      new_rsp.status = ST_INVALID;
    end

    // Error handling and end of expression
    if (discarding || (new_rsp.status != ST_ACCEPTED)) begin
      if (cmd.is_last) begin
        new_rsp.done_res = 1'b1;
        count_next       = '0;
        discarding_next  = 1'b0;
      end else begin
        discarding_next  = 1'b1;
      end
    end else if (cmd.is_last) begin
      if (count_next == '0) begin
        new_rsp.status = ST_TOO_FEW;
      end else begin
        value_ext      = {{RES_WIDTH{1'b0}}, tos_next};
        new_rsp.value  = value_ext[RES_WIDTH-1:0];
        new_rsp.status = (count_next == CW'(1)) ? ST_RESULT : ST_INCOMPLETE;
      end
      new_rsp.done_res = 1'b1;
      count_next       = '0;
      discarding_next  = 1'b0;
    end
  end

  // Read index of the entry that becomes third after this cycle
  assign rd_index = accept ? (count_next - CW'(3)) : (count - CW'(3));

  // Stack control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      count      <= count_next;
      discarding <= discarding_next;
    end
  end

  // Cached top entries
  always_ff @(posedge clk) begin
    if (accept) begin
      tos <= tos_next;
      nos <= nos_next;
    end
  end

  // Stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if ((accept ? count_next : count) >= CW'(3)) begin
      third <= stack_mem[rd_index[AW-1:0]];
    end
  end

  // Output buffer with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_item  <= new_rsp;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= new_rsp;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* sv/pee_chk.sv */
// ----------------------------------------------------------------------------
// Postfix evaluator checker
// Port-level assertions on the result channel and cmd_stall, bound to the evaluator.
// ----------------------------------------------------------------------------
module pee_chk
  import pee_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled result item stays and holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // A final value only travels with a result status
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_RESULT) && (rsp.status != ST_INCOMPLETE)
      |-> rsp.value == '0)
    else $error("nonzero value without a result status");

  // A result status always ends the expression
  a_result_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp.status == ST_RESULT) || (rsp.status == ST_INCOMPLETE))
      |-> rsp.done_res)
    else $error("result status without end of expression");

  // An accepted character never ends an expression
  a_accepted_open: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_ACCEPTED) |-> !rsp.done_res)
    else $error("accepted status marked as end of expression");

  // Reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !cmd_stall)
    else $error("output buffer not empty after reset");

endmodule

bind postfix_expression_evaluator_unit pee_chk u_pee_chk (.*);
